/* rtl/hbm_pkg.sv */
// Shared types and constants of the heartbeat monitor.
package hbm_pkg;

  localparam int MAX_TARGETS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int TARGET_W    = 4;
  localparam int NOW_W       = 32;
  localparam int TIMEOUT_W   = 32;
  localparam int TIU_W       = 5;
  localparam int MASK_W      = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd3000;
  localparam logic [TIU_W-1:0]     TIU_RST     = 5'd0;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGETS = 1'd1;

  // Command codes
  localparam logic CMD_HEARTBEAT = 1'b0;
  localparam logic CMD_CHECK     = 1'b1;

  typedef enum logic [1:0] {
    ST_NEVER   = 2'd0,
    ST_ONLINE  = 2'd1,
    ST_OFFLINE = 2'd2
  } status_t;

endpackage

/* rtl/multi_channel_heartbeat_monitor_unit.sv */
// Top level of the heartbeat timeout monitor: sequencer, status table and ports.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: cmd; tdata: target_id, now
//  out_    | out | out_tvalid/out_tready| tuser: matched; tdata: newly_offline, online
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_addr: register index, cfg_data: value
//
// A heartbeat result is loaded after its input transfer via the heartbeat and done steps; a check
// result follows the scan of the active targets, in which the last-seen RAM feeds one entry per
// cycle into the single subtract/compare unit.
// Input is ready only while idle, so no new item is taken before the last result is loaded;
// a result not yet taken holds the sequencer in its last step and so stalls the input.
// Sync active-low reset: never seen, last-seen zero, timeout 3000, none in use; cfg always ready.
module multi_channel_heartbeat_monitor_unit #(
  parameter int MAX_TARGETS = hbm_pkg::MAX_TARGETS_DEF,
  parameter int TIME_BITS   = hbm_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hbm_pkg::IN_TDATA_W-1:0]   in_tdata,   // [3:0] target_id, [35:4] now
  input  logic                             in_tuser,   // [0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hbm_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [15:0] newly_offline, [31:16] online
  output logic                             out_tuser,  // [0] matched
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hbm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
  localparam logic [7:0] MAX8 = 8'(MAX_TARGETS);
  localparam int MASK_N = (MAX_TARGETS < hbm_pkg::MASK_W) ? MAX_TARGETS : hbm_pkg::MASK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HB,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                        state_r;
  hbm_pkg::status_t              status_r [MAX_TARGETS];
  logic [hbm_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [hbm_pkg::TIU_W-1:0]     tiu_r;

  logic [hbm_pkg::TARGET_W-1:0]  id_r;
  logic [TIME_BITS-1:0]          now_r;
  logic                          matched_r;
  logic [hbm_pkg::MASK_W-1:0]    gone_r;
  logic [CNT_W-1:0]              rd_cnt_r;
  logic                          cmp_vld_r;
  logic [IDX_W-1:0]              cmp_idx_r;

  logic                          out_valid_r;
  logic                          out_matched_r;
  logic [hbm_pkg::MASK_W-1:0]    out_gone_r;
  logic [hbm_pkg::MASK_W-1:0]    out_online_r;

  logic [7:0]                    tiu8;
  logic [CNT_W-1:0]              n_act;
  logic                          hb_hit;
  logic [IDX_W-1:0]              hb_idx;
  logic                          rd_en;
  logic [TIME_BITS-1:0]          rd_last;
  logic                          expired;
  logic                          drop;
  logic [hbm_pkg::MASK_W-1:0]    online_mask;
  logic                          out_free;

  // active count, saturated at the table size
  assign tiu8  = 8'(tiu_r);
  assign n_act = (tiu8 > MAX8) ? MAX8[CNT_W-1:0] : tiu8[CNT_W-1:0];

  assign hb_hit = 8'(id_r) < 8'(n_act);
  assign hb_idx = IDX_W'(id_r);
  assign rd_en  = (state_r == S_SCAN) && (rd_cnt_r < n_act);

  hbm_time_ram #(
    .DEPTH  (MAX_TARGETS),
    .WIDTH  (TIME_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   ((state_r == S_HB) && hb_hit),
    .wr_addr (hb_idx),
    .wr_data (now_r),
    .rd_en   (rd_en),
    .rd_addr (rd_cnt_r[IDX_W-1:0]),
    .rd_data (rd_last)
  );

  hbm_diff_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_diff (
    .now     (now_r),
    .last    (rd_last),
    .timeout (timeout_r),
    .expired (expired)
  );

  // offline targets are skipped
  assign drop = cmp_vld_r && (status_r[cmp_idx_r] != hbm_pkg::ST_OFFLINE) && expired;

  genvar g;
  generate
    for (g = 0; g < hbm_pkg::MASK_W; g++) begin : g_mask
      if (g < MASK_N) begin : g_on
        assign online_mask[g] = (8'(g) < 8'(n_act)) &&
                                (status_r[g] == hbm_pkg::ST_ONLINE);
      end else begin : g_off
        assign online_mask[g] = 1'b0;
      end
    end
  endgenerate

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= hbm_pkg::TIMEOUT_RST;
      tiu_r     <= hbm_pkg::TIU_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        hbm_pkg::REG_TIMEOUT: timeout_r <= cfg_data;
        hbm_pkg::REG_TARGETS: tiu_r     <= cfg_data[hbm_pkg::TIU_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      id_r  <= in_tdata[hbm_pkg::TARGET_W-1:0];
      now_r <= TIME_BITS'(in_tdata[hbm_pkg::TARGET_W +: hbm_pkg::NOW_W]);
    end
  end

  // sequencer, status table and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_cnt_r    <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_idx_r   <= '0;
      matched_r   <= 1'b0;
      gone_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TARGETS; i++) begin
        status_r[i] <= hbm_pkg::ST_NEVER;
      end
    end else begin
      // a result loaded in S_DONE takes precedence over the drain
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          rd_cnt_r  <= '0;
          cmp_vld_r <= 1'b0;
          matched_r <= 1'b0;
          gone_r    <= '0;
          if (in_tvalid) begin
            state_r <= (in_tuser == hbm_pkg::CMD_CHECK) ? S_SCAN : S_HB;
          end
        end
        S_HB: begin
          if (hb_hit) begin
            status_r[hb_idx] <= hbm_pkg::ST_ONLINE;
            matched_r        <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_SCAN: begin
          // read stage issues one entry, compare stage judges the previous one
          cmp_vld_r <= rd_en;
          cmp_idx_r <= rd_cnt_r[IDX_W-1:0];
          if (rd_en) begin
            rd_cnt_r <= rd_cnt_r + 1'b1;
          end
          if (drop) begin
            status_r[cmp_idx_r] <= hbm_pkg::ST_OFFLINE;
            for (int j = 0; j < MASK_N; j++) begin
              if (8'(cmp_idx_r) == 8'(j)) begin
                gone_r[j] <= 1'b1;
              end
            end
          end
          if (!rd_en && !cmp_vld_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_matched_r <= matched_r;
            out_gone_r    <= gone_r;
            out_online_r  <= online_mask;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_matched_r;
  assign out_tdata  = {out_online_r, out_gone_r};

  // a target that went offline cannot also be reported online
  a_gone_not_online: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[15:0] & out_tdata[31:16]) == '0))
    else $error("target both newly offline and online");

  // a matched heartbeat never reports newly offline targets
  a_hb_no_gone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[15:0] == '0))
    else $error("heartbeat result carries offline bits");

  // the scan never runs past the active targets
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_cnt_r <= n_act))
    else $error("scan counter beyond active count");

  // an accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready straight after a transfer");

  // a result only loads while the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("pending result overwritten");

endmodule

/* rtl/hbm_time_ram.sv */
// Last-seen time store: one write port, one registered read port, zero until written.
module hbm_time_ram #(
  parameter int DEPTH  = hbm_pkg::MAX_TARGETS_DEF,
  parameter int WIDTH  = hbm_pkg::TIME_BITS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/hbm_diff_unit.sv */
// Shared modular subtract and timeout compare.
module hbm_diff_unit #(
  parameter int TIME_BITS = hbm_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0]         now,
  input  logic [TIME_BITS-1:0]         last,
  input  logic [hbm_pkg::TIMEOUT_W-1:0] timeout,
  output logic                         expired
);

  localparam int CMP_W = (TIME_BITS > hbm_pkg::TIMEOUT_W) ? TIME_BITS : hbm_pkg::TIMEOUT_W;

  logic [TIME_BITS-1:0] diff;

  assign diff    = now - last;  // wraps modulo 2^TIME_BITS
  assign expired = CMP_W'(diff) > CMP_W'(timeout);

endmodule

/* dv/tb_multi_channel_heartbeat_monitor_unit.sv */
// Self-checking testbench of the heartbeat timeout monitor: directed table, then random phases.
module tb_multi_channel_heartbeat_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limit in cycles; the slowest legal run is set by the checks, sender gaps and receiver stalls.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int SETTLE_CYCLES = 24;   // longer than a full-table check
  localparam int RANDOM_SETS = 8;
  localparam int ITEMS_PER_SET = 75;

  typedef struct packed {
    logic                       matched;
    logic [hbm_pkg::MASK_W-1:0] gone;
    logic [hbm_pkg::MASK_W-1:0] online;
  } hb_result_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  // One row of the directed table: either a register write or an item. An item
  // may carry a pinned result, used instead of the predicted one.
  typedef struct {
    row_kind_t                      kind;
    logic [hbm_pkg::CFG_ADDR_W-1:0] addr;
    logic [hbm_pkg::CFG_DATA_W-1:0] value;
    logic                           cmd;
    logic [hbm_pkg::TARGET_W-1:0]   id;
    logic [hbm_pkg::NOW_W-1:0]      now;
    bit                             pinned;
    hb_result_t                     want;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hbm_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hbm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [hbm_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [hbm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Pinned result travelling alongside the item on the input channel
  bit                     item_pinned = 1'b0;
  hb_result_t             item_want = '0;

  multi_channel_heartbeat_monitor_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the target table and both registers
  // ---------------------------------------------------------------------------
  logic [hbm_pkg::NOW_W-1:0]     seen_at [hbm_pkg::MAX_TARGETS_DEF];
  hbm_pkg::status_t              tgt_state [hbm_pkg::MAX_TARGETS_DEF];
  logic [hbm_pkg::TIMEOUT_W-1:0] timeout_q = hbm_pkg::TIMEOUT_RST;
  logic [hbm_pkg::TIU_W-1:0]     in_use_q = hbm_pkg::TIU_RST;

  hb_result_t pending_results[$];   // predicted results, oldest first
  hb_result_t predicted_r;
  hb_result_t observed_r;
  int         mismatch_count = 0;
  int         cycles = 0;
  int         gap_pct = 0;          // sender idle chance per item, percent
  int         stall_pct = 0;        // receiver stall chance per cycle, percent

  initial begin
    for (int i = 0; i < hbm_pkg::MAX_TARGETS_DEF; i++) begin
      seen_at[i] = '0;
      tgt_state[i] = hbm_pkg::ST_NEVER;
    end
  end

  // Heartbeat stores the time and brings the target online; check ages every
  // monitored target that is not already offline. Never-seen targets age from
  // time zero. Indices at or above the in-use count are left untouched.
  function automatic hb_result_t predict_monitor_result(logic cmd,
                                                        logic [hbm_pkg::TARGET_W-1:0] id,
                                                        logic [hbm_pkg::NOW_W-1:0] now);
    hb_result_t r;
    int n;
    int i;
    logic [hbm_pkg::NOW_W-1:0] age;
    r = '0;
    n = (in_use_q > hbm_pkg::MAX_TARGETS_DEF) ? hbm_pkg::MAX_TARGETS_DEF : int'(in_use_q);
    if (cmd == hbm_pkg::CMD_HEARTBEAT) begin
      if (int'(id) < n) begin
        seen_at[id] = now;
        tgt_state[id] = hbm_pkg::ST_ONLINE;
        r.matched = 1'b1;
      end
    end else begin
      for (i = 0; i < n; i++) begin
        age = now - seen_at[i];   // modular difference
        if (tgt_state[i] != hbm_pkg::ST_OFFLINE && age > timeout_q) begin
          tgt_state[i] = hbm_pkg::ST_OFFLINE;
          r.gone[i] = 1'b1;
        end
      end
    end
    for (i = 0; i < n; i++)
      if (tgt_state[i] == hbm_pkg::ST_ONLINE) r.online[i] = 1'b1;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input hb_result_t want,
                               input hb_result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected matched=%0b newly_offline=%h online=%h, %s",
               what, want.matched, want.gone, want.online,
               $sformatf("got matched=%0b newly_offline=%h online=%h",
                         seen.matched, seen.gone, seen.online));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before this edge's updates
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == hbm_pkg::REG_TIMEOUT)
          timeout_q = cfg_data[hbm_pkg::TIMEOUT_W-1:0];
        else if (cfg_addr == hbm_pkg::REG_TARGETS)
          in_use_q = cfg_data[hbm_pkg::TIU_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        predicted_r = predict_monitor_result(in_tuser, in_tdata[hbm_pkg::TARGET_W-1:0],
                                             in_tdata[hbm_pkg::TARGET_W +: hbm_pkg::NOW_W]);
        if (item_pinned) predicted_r = item_want;
        pending_results.push_back(predicted_r);
      end
      if (out_tvalid && out_tready) begin
        observed_r.matched = out_tuser;
        observed_r.gone    = out_tdata[hbm_pkg::MASK_W-1:0];
        observed_r.online  = out_tdata[hbm_pkg::MASK_W +: hbm_pkg::MASK_W];
        if (pending_results.size() == 0) begin
          note_mismatch("result transfer with nothing expected", '0, observed_r);
        end else begin
          predicted_r = pending_results.pop_front();
          if (observed_r.matched !== predicted_r.matched ||
              observed_r.gone !== predicted_r.gone ||
              observed_r.online !== predicted_r.online)
            note_mismatch("result mismatch", predicted_r, observed_r);
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk)
    out_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_multi_channel_heartbeat_monitor_unit failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------

  // Offer one item, with a random idle gap ahead of it, and return at the edge
  // where the transfer happens. tvalid stays high for a following item.
  task automatic send_item(input logic cmd, input logic [hbm_pkg::TARGET_W-1:0] id,
                           input logic [hbm_pkg::NOW_W-1:0] now, input bit pinned,
                           input hb_result_t want);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser    <= cmd;
    in_tdata    <= {{(hbm_pkg::IN_TDATA_W - hbm_pkg::NOW_W - hbm_pkg::TARGET_W){1'b0}},
                    now, id};
    item_pinned <= pinned;
    item_want   <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering items and wait until every predicted result has come back,
  // then give the sequencer time to settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only ever with the block idle
  task automatic write_reg(input logic [hbm_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [hbm_pkg::CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows[$];

  function automatic void add_reg(logic [hbm_pkg::CFG_ADDR_W-1:0] addr,
                                  logic [hbm_pkg::CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '{kind: ROW_REG, addr: addr, value: value, cmd: 1'b0, id: '0, now: '0,
            pinned: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_item(logic cmd, logic [hbm_pkg::TARGET_W-1:0] id,
                                   logic [hbm_pkg::NOW_W-1:0] now,
                                   bit pinned = 1'b0, hb_result_t want = '0);
    stim_row_t row;
    row = '{kind: ROW_ITEM, addr: '0, value: '0, cmd: cmd, id: id, now: now,
            pinned: pinned, want: want};
    directed_rows.push_back(row);
  endfunction

  initial begin
    // Out of reset nothing is in use: heartbeats unmatched, checks empty
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd0, 32'd0, 1'b1, '{1'b0, 16'h0000, 16'h0000});
    add_item(hbm_pkg::CMD_CHECK, 4'd9, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'h0000, 16'h0000});
    // In-use count beyond the table saturates to the full table
    add_reg(hbm_pkg::REG_TARGETS, 32'd31);
    add_reg(hbm_pkg::REG_TIMEOUT, 32'd100);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd15, 32'd1000, 1'b1, '{1'b1, 16'h0000, 16'h8000});
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd0, 32'hFFFF_FFF0, 1'b1,
             '{1'b1, 16'h0000, 16'h8001});
    // Wrapped difference: target 0 is young, target 15 looks very old
    add_item(hbm_pkg::CMD_CHECK, 4'd3, 32'd50);
    // Never-seen targets age from zero and drop out too
    add_item(hbm_pkg::CMD_CHECK, 4'd0, 32'd160);
    // An offline target comes back on its next heartbeat
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd15, 32'd5);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd7, 32'd123);
    // Shrink the table: index 4 is out of use, online targets above are hidden
    add_reg(hbm_pkg::REG_TARGETS, 32'd4);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd4, 32'd77, 1'b1, '{1'b0, 16'h0000, 16'h0000});
    add_item(hbm_pkg::CMD_CHECK, 4'd15, 32'hFFFF_FFFF);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd3, 32'd1000, 1'b1, '{1'b1, 16'h0000, 16'h0008});
    // Zero timeout: equal time survives, one tick later is offline
    add_reg(hbm_pkg::REG_TIMEOUT, 32'd0);
    add_item(hbm_pkg::CMD_CHECK, 4'd0, 32'd1000, 1'b1, '{1'b0, 16'h0000, 16'h0008});
    add_item(hbm_pkg::CMD_CHECK, 4'd0, 32'd1001, 1'b1, '{1'b0, 16'h0008, 16'h0000});
    // Largest timeout: even the maximal difference is not a timeout
    add_reg(hbm_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd2, 32'd0);
    add_item(hbm_pkg::CMD_CHECK, 4'd1, 32'hFFFF_FFFF);
    add_reg(hbm_pkg::REG_TARGETS, 32'd17);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd10, 32'hAAAA_AAAA);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd5, 32'h5555_5555);
    add_item(hbm_pkg::CMD_CHECK, 4'd6, 32'h1234_5678);
    add_reg(hbm_pkg::REG_TARGETS, 32'd16);
    add_item(hbm_pkg::CMD_HEARTBEAT, 4'd15, 32'hFFFF_FFFF);
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [hbm_pkg::TIMEOUT_W-1:0] timeout_set;
    int unsigned                   in_use_set;
    int unsigned                   active;
    int unsigned                   span;
    logic [hbm_pkg::NOW_W-1:0]     clock_now;
    logic [hbm_pkg::NOW_W-1:0]     now;
    logic                          cmd;
    logic [hbm_pkg::TARGET_W-1:0]  id;
    int                            roll;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling on either side
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_REG)
        write_reg(directed_rows[k].addr, directed_rows[k].value);
      else
        send_item(directed_rows[k].cmd, directed_rows[k].id, directed_rows[k].now,
                  directed_rows[k].pinned, directed_rows[k].want);
    end

    // Random part: each pair of sets shares one idling pattern
    for (int set = 0; set < RANDOM_SETS; set++) begin
      case (set % 4)
        0:       timeout_set = 32'd1;
        1:       timeout_set = $urandom_range(20, 500);
        2:       timeout_set = $urandom_range(1000, 100000);
        default: timeout_set = (set == 3) ? 32'hFFFF_FFFF : $urandom();
      endcase
      case (set % 4)
        0:       in_use_set = 16;
        1:       in_use_set = $urandom_range(1, 15);
        2:       in_use_set = $urandom_range(17, 31);   // saturates
        default: in_use_set = $urandom_range(1, 16);
      endcase
      write_reg(hbm_pkg::REG_TIMEOUT, timeout_set);
      write_reg(hbm_pkg::REG_TARGETS, in_use_set);

      case (set / 2)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 69; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 69; end
        default: begin gap_pct = 18; stall_pct = 18; end
      endcase

      active    = (in_use_set > 16) ? 16 : in_use_set;
      span      = (timeout_set >> 2) + 2;
      clock_now = $urandom();

      // Mostly a running clock with heartbeats to targets in use and periodic
      // checks, so targets go offline and come back; a tenth is pure noise.
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          cmd = $urandom_range(0, 1);
          id  = $urandom_range(0, 15);
          now = $urandom();
        end else begin
          clock_now = clock_now + $urandom_range(0, span);
          now = clock_now;
          if (roll < 60) begin
            cmd = hbm_pkg::CMD_HEARTBEAT;
            id  = (roll < 55) ? $urandom_range(0, active - 1) : $urandom_range(0, 15);
          end else begin
            cmd = hbm_pkg::CMD_CHECK;
            id  = $urandom_range(0, 15);
          end
        end
        send_item(cmd, id, now, 1'b0, '0);
      end
    end

    gap_pct = 0;
    wait_drained();
    stall_pct = 0;

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("tb_multi_channel_heartbeat_monitor_unit passed");
    else
      $display("tb_multi_channel_heartbeat_monitor_unit failed");
    $finish;
  end

endmodule
